// ===== rtl/otsu_pkg.sv =====
`timescale 1ns / 1ps
package otsu_pkg;

    localparam int COUNT_WIDTH = 23;
    localparam int LEVELS      = 256;
    localparam int LVL_W       = 8;
    localparam int SUM_W       = COUNT_WIDTH + LVL_W;     // sum of levels
    localparam int DIFF_W      = SUM_W + COUNT_WIDTH;     // S*W0, N*M0
    localparam int NUM_W       = 2 * DIFF_W;              // squared difference
    localparam int DEN_W       = 2 * COUNT_WIDTH;         // W0*(N-W0)
    localparam int MA_W        = NUM_W;
    localparam int MB_W        = DIFF_W;
    localparam int MP_W        = MA_W + MB_W;
    localparam int LEN_W       = $clog2(MB_W + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [LVL_W-1:0]       PIX_HI    = LVL_W'(255);
    localparam logic [LVL_W-1:0]       PIX_LO    = '0;
    localparam logic [LVL_W-1:0]       LVL_LAST  = LVL_W'(LEVELS - 1);

    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_BIN     = 1'b1;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_THR   = 1'b1;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } mul_cmd_t;

endpackage

// ===== rtl/otsu_in_if.sv =====
`timescale 1ns / 1ps
interface otsu_in_if import otsu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [LVL_W-1:0] pixel;
    logic             last;

    modport source (output valid, output operation, output pixel, output last, input ready);
    modport sink   (input valid, input operation, input pixel, input last, output ready);
endinterface

// ===== rtl/otsu_out_if.sv =====
`timescale 1ns / 1ps
interface otsu_out_if import otsu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [LVL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/otsu_mul.sv =====
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle.
module otsu_mul import otsu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  mul_cmd_t        cmd,
    input  logic [MA_W-1:0] a,
    input  logic [MB_W-1:0] b,
    output logic            done,
    output logic [MP_W-1:0] prod
);

    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [MP_W-1:0]  a_reg;
    logic [MB_W-1:0]  b_reg;
    logic [MP_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.len;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - LEN_W'(1);
                if (cnt_reg == LEN_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= MP_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/otsu_threshold_binarizer_unit.sv =====
`timescale 1ns / 1ps
// Otsu threshold binarizer for 8-bit gray levels. Pass-one requests (operation 0) add
// their pixel to a 256-bin histogram held in a single-port-read/single-port-write RAM,
// at one request per cycle while the result side keeps up; no result is returned unless
// last is set. A pass-one request with last starts the threshold sweep: input is stalled
// while each level is read back from the RAM and scored on one shared shift-add
// multiplier. A level where a class is empty is skipped without products, the first valid
// candidate takes four products and later ones six (of 23, 23, 54, 23, 46 and 46
// multiplier bits); then one threshold result (kind 1) is returned and the histogram is
// cleared at once through per-bin valid flags. Pass-two requests (operation 1) return 255
// for a pixel above the stored threshold, else 0, at one per cycle while the result side
// keeps up. The threshold is 0 after reset and whenever no level splits the pixels into
// two classes.
module otsu_threshold_binarizer_unit import otsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    otsu_in_if.sink     pixels,
    otsu_out_if.source  results
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_DRAIN = 12'b0000_0000_0010,
        ST_RD    = 12'b0000_0000_0100,
        ST_LD    = 12'b0000_0000_1000,
        ST_MP    = 12'b0000_0001_0000,
        ST_MQ    = 12'b0000_0010_0000,
        ST_MN    = 12'b0000_0100_0000,
        ST_MD    = 12'b0000_1000_0000,
        ST_ML    = 12'b0001_0000_0000,
        ST_MR    = 12'b0010_0000_0000,
        ST_ADV   = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    // histogram RAM and per-bin valid flags (a clear flag reads as zero)
    logic [COUNT_WIDTH-1:0] hist_mem [LEVELS];
    logic [LEVELS-1:0]      hv_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic [LVL_W-1:0]       raddr;

    // increment stage and write-forwarding register
    logic                   s1_valid_reg;
    logic [LVL_W-1:0]       s1_addr_reg;
    logic                   wr_valid_reg;
    logic [LVL_W-1:0]       wr_addr_reg;
    logic [COUNT_WIDTH-1:0] wr_data_reg;
    logic [COUNT_WIDTH-1:0] s1_old;
    logic [COUNT_WIDTH-1:0] s1_new;

    // frame totals
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [SUM_W-1:0]       total_reg;
    logic [LVL_W-1:0]       thr_reg;

    // sweep state
    logic [LVL_W-1:0]       t_reg;
    logic [COUNT_WIDTH-1:0] h_reg;
    logic [COUNT_WIDTH-1:0] w0_reg;
    logic [SUM_W-1:0]       m0_reg;
    logic [DIFF_W-1:0]      p_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [MP_W-1:0]        lhs_reg;
    logic [NUM_W-1:0]       bn_reg;
    logic [DEN_W-1:0]       bd_reg;
    logic                   best_found_reg;
    logic [LVL_W-1:0]       choice_reg;
    logic [DIFF_W-1:0]      q_val;
    logic [DIFF_W-1:0]      diff;

    // shared multiplier
    mul_cmd_t               mul_cmd_reg;
    logic [MA_W-1:0]        mul_a_reg;
    logic [MB_W-1:0]        mul_b_reg;
    logic                   mul_done;
    logic [MP_W-1:0]        mul_prod;

    // result register
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [LVL_W-1:0]       out_value_reg;

    logic                   out_free;
    logic                   in_acc;
    logic                   add_acc;
    logic                   cnt_ok;
    logic                   split_ok;

    assign out_free = !out_valid_reg || results.ready;
    assign pixels.ready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = pixels.valid && pixels.ready;
    assign add_acc  = in_acc && (pixels.operation == OP_ADD);
    assign cnt_ok   = (count_reg != COUNT_MAX);

    assign results.valid = out_valid_reg;
    assign results.kind  = out_kind_reg;
    assign results.value = out_value_reg;

    assign raddr = (state_reg == ST_RD) ? t_reg : pixels.pixel;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            hist_mem[s1_addr_reg] <= s1_new;
        end
        rd_data_reg <= hist_mem[raddr];
    end

    // a write issued in the cycle of the read is seen only through forwarding
    assign s1_old = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg
                  : (rd_vld_reg ? rd_data_reg : '0);
    assign s1_new = s1_old + COUNT_WIDTH'(1);

    assign split_ok = (w0_reg != '0) && (w0_reg != count_reg);
    assign q_val    = mul_prod[DIFF_W-1:0];
    assign diff     = (p_reg >= q_val) ? (p_reg - q_val) : (q_val - p_reg);

    otsu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // control path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hv_reg         <= '0;
            rd_vld_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            wr_valid_reg   <= 1'b0;
            count_reg      <= '0;
            total_reg      <= '0;
            thr_reg        <= '0;
            t_reg          <= '0;
            w0_reg         <= '0;
            m0_reg         <= '0;
            best_found_reg <= 1'b0;
            mul_cmd_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mul_cmd_reg.start <= 1'b0;
            rd_vld_reg        <= hv_reg[raddr];
            s1_valid_reg      <= add_acc && cnt_ok;

            if (s1_valid_reg)
            begin
                hv_reg[s1_addr_reg] <= 1'b1;
                wr_valid_reg        <= 1'b1;
            end

            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (add_acc && cnt_ok)
            begin
                count_reg <= count_reg + COUNT_WIDTH'(1);
                total_reg <= total_reg + SUM_W'(pixels.pixel);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (pixels.operation == OP_BIN))
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (add_acc && pixels.last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    t_reg          <= '0;
                    w0_reg         <= '0;
                    m0_reg         <= '0;
                    best_found_reg <= 1'b0;
                    state_reg      <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_LD;
                end
                ST_LD:
                begin
                    if (split_ok)
                    begin
                        mul_cmd_reg <= '{start: 1'b1, len: LEN_W'(COUNT_WIDTH)};
                        state_reg   <= ST_MP;
                    end
                    else
                    begin
                        state_reg <= ST_ADV;
                    end
                end
                ST_MP:
                begin
                    if (mul_done)
                    begin
                        mul_cmd_reg <= '{start: 1'b1, len: LEN_W'(COUNT_WIDTH)};
                        state_reg   <= ST_MQ;
                    end
                end
                ST_MQ:
                begin
                    if (mul_done)
                    begin
                        mul_cmd_reg <= '{start: 1'b1, len: LEN_W'(DIFF_W)};
                        state_reg   <= ST_MN;
                    end
                end
                ST_MN:
                begin
                    if (mul_done)
                    begin
                        mul_cmd_reg <= '{start: 1'b1, len: LEN_W'(COUNT_WIDTH)};
                        state_reg   <= ST_MD;
                    end
                end
                ST_MD:
                begin
                    if (mul_done)
                    begin
                        if (!best_found_reg)
                        begin
                            best_found_reg <= 1'b1;
                            state_reg      <= ST_ADV;
                        end
                        else
                        begin
                            mul_cmd_reg <= '{start: 1'b1, len: LEN_W'(DEN_W)};
                            state_reg   <= ST_ML;
                        end
                    end
                end
                ST_ML:
                begin
                    if (mul_done)
                    begin
                        mul_cmd_reg <= '{start: 1'b1, len: LEN_W'(DEN_W)};
                        state_reg   <= ST_MR;
                    end
                end
                ST_MR:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV:
                begin
                    w0_reg <= w0_reg + h_reg;
                    m0_reg <= m0_reg + (SUM_W'(t_reg) * SUM_W'(h_reg));
                    if (t_reg == LVL_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        t_reg     <= t_reg + LVL_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        thr_reg       <= best_found_reg ? choice_reg : PIX_LO;
                        out_valid_reg <= 1'b1;
                        hv_reg        <= '0;
                        wr_valid_reg  <= 1'b0;
                        count_reg     <= '0;
                        total_reg     <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= pixels.pixel;
        if (s1_valid_reg)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= s1_new;
        end

        if (in_acc && (pixels.operation == OP_BIN))
        begin
            out_kind_reg  <= KIND_PIXEL;
            out_value_reg <= (pixels.pixel > thr_reg) ? PIX_HI : PIX_LO;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_kind_reg  <= KIND_THR;
            out_value_reg <= best_found_reg ? choice_reg : PIX_LO;
        end

        unique case (state_reg)
            ST_LD:
            begin
                h_reg     <= rd_vld_reg ? rd_data_reg : '0;
                mul_a_reg <= MA_W'(total_reg);           // S*W0
                mul_b_reg <= MB_W'(w0_reg);
            end
            ST_MP:
            begin
                if (mul_done)
                begin
                    p_reg     <= mul_prod[DIFF_W-1:0];
                    mul_a_reg <= MA_W'(m0_reg);          // N*M0
                    mul_b_reg <= MB_W'(count_reg);
                end
            end
            ST_MQ:
            begin
                if (mul_done)
                begin
                    mul_a_reg <= MA_W'(diff);            // squared difference
                    mul_b_reg <= diff;
                end
            end
            ST_MN:
            begin
                if (mul_done)
                begin
                    num_reg   <= mul_prod[NUM_W-1:0];
                    mul_a_reg <= MA_W'(w0_reg);          // W0*(N-W0)
                    mul_b_reg <= MB_W'(count_reg - w0_reg);
                end
            end
            ST_MD:
            begin
                if (mul_done)
                begin
                    den_reg   <= mul_prod[DEN_W-1:0];
                    mul_a_reg <= num_reg;                // new score cross term
                    mul_b_reg <= MB_W'(bd_reg);
                    if (!best_found_reg)
                    begin
                        bn_reg     <= num_reg;
                        bd_reg     <= mul_prod[DEN_W-1:0];
                        choice_reg <= t_reg;
                    end
                end
            end
            ST_ML:
            begin
                if (mul_done)
                begin
                    lhs_reg   <= mul_prod;
                    mul_a_reg <= bn_reg;                 // best score cross term
                    mul_b_reg <= MB_W'(den_reg);
                end
            end
            ST_MR:
            begin
                // strictly greater only, so the lowest level keeps a tie
                if (mul_done && (lhs_reg > mul_prod))
                begin
                    bn_reg     <= num_reg;
                    bd_reg     <= den_reg;
                    choice_reg <= t_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== tb/otsu_threshold_binarizer_unit_tb.sv =====
`timescale 1ns / 1ps
// Otsu binarizer bench: a queue-fed driver offers pixel requests, a monitor scores
// every result against a local predictor of the histogram and the threshold sweep.
module otsu_threshold_binarizer_unit_tb;
    import otsu_pkg::*;

    typedef struct packed {
        logic             operation;
        logic [LVL_W-1:0] pixel;
        logic             last;
    } pix_req_t;

    typedef struct packed {
        logic             kind;
        logic [LVL_W-1:0] value;
    } otsu_result_t;

    localparam int LIMIT_CYCLES = 30_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    otsu_in_if  pixels ();
    otsu_out_if results ();

    otsu_threshold_binarizer_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels.sink),
        .results (results.source)
    );

    always #5 clk = ~clk;

    // Predictor state, mirrors the block's histogram and stored threshold.
    int unsigned bin_count [LEVELS];
    int unsigned frame_pixels;
    logic [LVL_W-1:0] thr_level;

    pix_req_t     pending_reqs [$];
    otsu_result_t expected_results [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  in_taken = 1'b0;    // request accepted at the last rising edge
    int  idle_pct = 12;      // percent chance of idling per cycle on either side
    int  hold_off = 0;       // receiver stall stretch, cycles remaining
    bit  sender_pause = 1'b0;

    // Exact Otsu sweep: score (S*W0-N*M0)^2/(W0*(N-W0)), first maximum wins.
    function automatic logic [LVL_W-1:0] otsu_sweep();
        logic [63:0]  total_sum, w0, m0, n, p, q, diff, den, best_den;
        logic [127:0] num, best_num;
        logic [191:0] lhs, rhs;
        bit           found;
        logic [LVL_W-1:0] pick;
        total_sum = 0; w0 = 0; m0 = 0; n = frame_pixels;
        found = 1'b0; best_num = 0; best_den = 0; pick = '0;
        for (int t = 0; t < LEVELS; t++)
            total_sum += 64'(t) * bin_count[t];
        for (int t = 0; t < LEVELS; t++)
        begin
            if (w0 != 0 && w0 != n)
            begin
                p = total_sum * w0;
                q = n * m0;
                diff = (p >= q) ? p - q : q - p;
                den = w0 * (n - w0);
                num = 128'(diff) * 128'(diff);
                lhs = 192'(num) * 192'(best_den);
                rhs = 192'(best_num) * 192'(den);
                if (!found || lhs > rhs)
                begin
                    found = 1'b1;
                    best_num = num;
                    best_den = den;
                    pick = LVL_W'(t);
                end
            end
            w0 += bin_count[t];
            m0 += 64'(t) * bin_count[t];
        end
        return found ? pick : '0;
    endfunction

    function automatic void predict_request(pix_req_t req);
        otsu_result_t res;
        if (req.operation == OP_BIN)
        begin
            res.kind  = KIND_PIXEL;
            res.value = (req.pixel > thr_level) ? PIX_HI : PIX_LO;
            expected_results.push_back(res);
            return;
        end
        if (frame_pixels < COUNT_MAX)
        begin
            bin_count[req.pixel]++;
            frame_pixels++;
        end
        if (req.last)
        begin
            thr_level = otsu_sweep();
            foreach (bin_count[i])
                bin_count[i] = 0;
            frame_pixels = 0;
            res.kind  = KIND_THR;
            res.value = thr_level;
            expected_results.push_back(res);
        end
    endfunction

    function automatic void add_req(logic op, logic [LVL_W-1:0] pix, logic lst);
        pix_req_t req;
        req.operation = op;
        req.pixel     = pix;
        req.last      = lst;
        pending_reqs.push_back(req);
    endfunction

    // Driver: change inputs on the falling edge; a request is replaced only once it was
    // accepted at the preceding rising edge.
    always @(negedge clk)
    begin
        if (rst_n && (!pixels.valid || in_taken))
        begin
            if (pending_reqs.size() > 0 && !sender_pause && $urandom_range(99) >= idle_pct)
            begin
                pix_req_t req;
                req = pending_reqs.pop_front();
                pixels.valid     <= 1'b1;
                pixels.operation <= req.operation;
                pixels.pixel     <= req.pixel;
                pixels.last      <= req.last;
            end
            else
                pixels.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && pixels.valid && pixels.ready;
        if (rst_n && pixels.valid && pixels.ready)
            predict_request('{pixels.operation, pixels.pixel, pixels.last});
    end

    // Receiver ready, with occasional long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            results.ready <= 1'b0;
        end
        else
            results.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && results.valid && results.ready)
        begin
            otsu_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d value=%0d",
                         $time, results.kind, results.value);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (results.kind !== want.kind)
                begin
                    $display("%0t: kind mismatch expected %0d actual %0d",
                             $time, want.kind, results.kind);
                    error_count++;
                end
                if (results.value !== want.value)
                begin
                    $display("%0t: value mismatch expected %0d actual %0d",
                             $time, want.value, results.value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || pixels.valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // Random frame: mostly short histograms, sometimes with few distinct levels.
    task automatic add_frame();
        int len;
        int lo;
        int span;
        len  = $urandom_range(40, 1);
        lo   = $urandom_range(255);
        span = ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
        for (int i = 0; i < len; i++)
            add_req(OP_ADD, 8'(lo + $urandom_range(span)), (i == len - 1));
        for (int i = $urandom_range(15); i > 0; i--)
            add_req(OP_BIN, 8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int n_items;
        foreach (bin_count[i])
            bin_count[i] = 0;
        frame_pixels = 0;
        thr_level = '0;
        pixels.valid = 1'b0;
        pixels.operation = OP_ADD;
        pixels.pixel = '0;
        pixels.last = 1'b0;
        results.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: binarize before any sweep (threshold 0), one-pixel and single-level
        // frames, ties, extremes of the pixel range.
        add_req(OP_BIN, 8'd0, 1'b0);
        add_req(OP_BIN, 8'd1, 1'b1);
        add_req(OP_BIN, 8'd255, 1'b0);
        add_req(OP_ADD, 8'd200, 1'b1);            // one pixel: no valid candidate
        add_req(OP_ADD, 8'd0, 1'b0);
        add_req(OP_ADD, 8'd0, 1'b1);              // all on one level
        add_req(OP_ADD, 8'd0, 1'b0);
        add_req(OP_ADD, 8'd255, 1'b1);            // extremes, many equal scores
        add_req(OP_BIN, 8'd254, 1'b0);
        add_req(OP_BIN, 8'd255, 1'b0);
        add_req(OP_ADD, 8'd10, 1'b0);
        add_req(OP_ADD, 8'd20, 1'b0);
        add_req(OP_ADD, 8'd30, 1'b0);
        add_req(OP_ADD, 8'd40, 1'b1);
        add_req(OP_BIN, 8'hAA, 1'b0);
        add_req(OP_BIN, 8'h55, 1'b1);
        drain();

        // Pressure: receiver holds off while binarize requests pile up.
        hold_off = 300;
        for (int i = 0; i < 60; i++)
            add_req(OP_BIN, 8'($urandom), 1'b0);
        drain();

        // Long stretch with no idling.
        idle_pct = 0;
        for (int i = 0; i < 6; i++)
            add_frame();
        drain();
        idle_pct = 12;

        n_items = 0;
        while (n_items < 1500)
        begin
            int before_sz;
            before_sz = pending_reqs.size();
            if ($urandom_range(9) == 0)
                add_req(1'($urandom), 8'($urandom), 1'b0);  // stray request
            else
                add_frame();
            n_items += pending_reqs.size() - before_sz;
            if ($urandom_range(30) == 0)
            begin
                sender_pause = 1'b1;   // hold new requests until results catch up
                while (expected_results.size() > 0 || pixels.valid)
                    @(posedge clk);
                sender_pause = 1'b0;
            end
            while (pending_reqs.size() > 50)
                @(posedge clk);
        end
        add_req(OP_ADD, 8'($urandom), 1'b1);
        drain();
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/otsu_pkg.sv
rtl/otsu_in_if.sv
rtl/otsu_out_if.sv
rtl/otsu_mul.sv
rtl/otsu_threshold_binarizer_unit.sv
tb/otsu_threshold_binarizer_unit_tb.sv
